[src/hpt_pkg.sv]
// ----------------------------------------------------------------------------
// hpt_pkg
// shared constants and types of the homogeneous point transform
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_W         = 64;
	localparam int FX_W          = 32;
	localparam int SUM_W         = 66;
	localparam int MAG_W         = 64;
	localparam int QBITS         = 33;
	localparam int REM_W         = 65;
	localparam int LANES         = 3;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

	typedef logic [3:0][3:0][FX_W-1:0] hpt_mat_t;

	typedef struct packed {
		logic [LANES-1:0][SUM_W-1:0] num;
		logic [SUM_W-1:0]            den;
	} hpt_sum_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hpt_q_stat_t;

	typedef struct packed {
		logic [LANES-1:0][MAG_W-1:0] nmag;
		logic [LANES-1:0]            nneg;
		logic [LANES-1:0]            nzero;
		logic [LANES-1:0]            big;
		logic [MAG_W-1:0]            dmag;
		logic                        dneg;
		logic                        dzero;
	} hpt_ctx_t;

endpackage

[src/hpt_front.sv]
// ----------------------------------------------------------------------------
// hpt_front
// accepts points, forms the four homogeneous row sums and pushes them
// ----------------------------------------------------------------------------
module hpt_front import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hpt_mat_t               mat,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [FX_W-1:0] in_x,
	input  logic signed [FX_W-1:0] in_y,
	input  logic signed [FX_W-1:0] in_z,
	input  hpt_q_stat_t            q_stat,
	output logic                   push,
	output hpt_sum_t               push_data
);

	logic                          v_s1, v_s2;
	logic signed [2*FX_W-1:0]      prod_s1 [4][3];
	logic signed [FX_W-1:0]        trans_s1 [4];
	logic signed [SUM_W-2:0]       pa_s2 [4];
	logic signed [SUM_W-1:0]       pb_s2 [4];
	logic                          adv;

	assign adv      = !v_s2 || !q_stat.full;
	assign in_ready = adv;
	assign push     = v_s2 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= (2*FX_W)'(in_x) * (2*FX_W)'($signed(mat[0][r]));
				prod_s1[r][1] <= (2*FX_W)'(in_y) * (2*FX_W)'($signed(mat[1][r]));
				prod_s1[r][2] <= (2*FX_W)'(in_z) * (2*FX_W)'($signed(mat[2][r]));
				trans_s1[r]   <= $signed(mat[3][r]);
				pa_s2[r]      <= (SUM_W-1)'(prod_s1[r][0]) + (SUM_W-1)'(prod_s1[r][1]);
				pb_s2[r]      <= SUM_W'(prod_s1[r][2]) + (SUM_W'(trans_s1[r]) <<< FRAC_BITS);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < LANES; r++)
			push_data.num[r] = SUM_W'(pa_s2[r]) + pb_s2[r];
		push_data.den = SUM_W'(pa_s2[3]) + pb_s2[3];
	end

endmodule

[src/hpt_queue.sv]
// ----------------------------------------------------------------------------
// hpt_queue
// short queue between front and back
// ----------------------------------------------------------------------------
module hpt_queue import hpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hpt_sum_t    push_data,
	input  logic        pop,
	output hpt_sum_t    pop_data,
	output hpt_q_stat_t q_stat,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	hpt_sum_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q;

	assign count        = count_q;
	assign q_stat.full  = (count_q == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= push_data;
	end

endmodule

[src/hpt_back.sv]
// ----------------------------------------------------------------------------
// hpt_back
// pipelined restoring divide of three numerators by w, saturation, output
// ----------------------------------------------------------------------------
module hpt_back import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hpt_q_stat_t            q_stat,
	input  hpt_sum_t               pop_data,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [FX_W-1:0] out_x,
	output logic signed [FX_W-1:0] out_y,
	output logic signed [FX_W-1:0] out_z,
	output logic                   divide_fault
);

	localparam int NW = MAG_W + FRAC_BITS;

	logic                  adv;
	logic                  v_s1;
	hpt_ctx_t              ctx_s1;
	logic                  vld_sn [QBITS+1];
	hpt_ctx_t              ctx_sn [QBITS+1];
	logic [REM_W-1:0]      rem_sn [QBITS+1][LANES];
	logic [QBITS-1:0]      quo_sn [QBITS+1][LANES];
	logic [REM_W-1:0]      rem_d  [QBITS+1][LANES];
	logic [QBITS-1:0]      quo_d  [QBITS+1][LANES];
	logic [LANES-1:0]      big_d;
	logic [REM_W-1:0]      rem0_d [LANES];
	hpt_ctx_t              ctx1_d;
	hpt_ctx_t              ctx0_d;
	logic                  out_valid_q;
	logic [FX_W-1:0]       res_q [LANES];
	logic                  fault_q;
	logic [FX_W-1:0]       res_d [LANES];
	logic                  fault_d;

	assign adv          = !out_valid_q || out_ready;
	assign pop          = adv && !q_stat.empty;
	assign out_valid    = out_valid_q;
	assign out_x        = res_q[0];
	assign out_y        = res_q[1];
	assign out_z        = res_q[2];
	assign divide_fault = fault_q;

	// magnitudes and signs
	always_comb begin
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] m;
		for (int l = 0; l < LANES; l++) begin
			s = pop_data.num[l];
			m = s[SUM_W-1] ? (~s + 1'b1) : s;
			ctx1_d.nmag[l]  = m[MAG_W-1:0];
			ctx1_d.nneg[l]  = s[SUM_W-1];
			ctx1_d.nzero[l] = (s == '0);
			ctx1_d.big[l]   = 1'b0;
		end
		s = pop_data.den;
		m = s[SUM_W-1] ? (~s + 1'b1) : s;
		ctx1_d.dmag  = m[MAG_W-1:0];
		ctx1_d.dneg  = s[SUM_W-1];
		ctx1_d.dzero = (s == '0);
	end

	// initial remainder and overflow test
	always_comb begin
		logic [NW-1:0] n;
		for (int l = 0; l < LANES; l++) begin
			n         = {ctx_s1.nmag[l], {FRAC_BITS{1'b0}}};
			rem0_d[l] = REM_W'(n[NW-1:QBITS]);
			big_d[l]  = REM_W'(n[NW-1:QBITS]) >= REM_W'(ctx_s1.dmag);
		end
		ctx0_d     = ctx_s1;
		ctx0_d.big = big_d;
	end

	// one quotient bit per stage
	always_comb begin
		logic [NW-1:0]    n;
		logic [REM_W-1:0] r2;
		logic             ge;
		for (int k = 0; k <= QBITS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_d[k][l] = '0;
				quo_d[k][l] = '0;
			end
		end
		for (int k = 1; k <= QBITS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				n  = {ctx_sn[k-1].nmag[l], {FRAC_BITS{1'b0}}};
				r2 = {rem_sn[k-1][l][REM_W-2:0], n[QBITS-k]};
				ge = r2 >= REM_W'(ctx_sn[k-1].dmag);
				rem_d[k][l] = ge ? r2 - REM_W'(ctx_sn[k-1].dmag) : r2;
				quo_d[k][l] = {quo_sn[k-1][l][QBITS-2:0], ge};
			end
		end
	end

	// saturation and sign
	always_comb begin
		hpt_ctx_t        c;
		logic            neg;
		logic            over;
		logic [QBITS-1:0] q;
		logic [QBITS-1:0] lim;
		c       = ctx_sn[QBITS];
		fault_d = 1'b0;
		neg     = 1'b0;
		over    = 1'b0;
		q       = '0;
		lim     = '0;
		for (int l = 0; l < LANES; l++) begin
			if (c.dzero) begin
				fault_d  = 1'b1;
				res_d[l] = c.nzero[l] ? '0 : (c.nneg[l] ? FX_MIN : FX_MAX);
			end else begin
				neg  = c.nneg[l] ^ c.dneg;
				lim  = neg ? QBITS'(FX_MIN) : QBITS'(FX_MAX);
				q    = quo_sn[QBITS][l];
				over = c.big[l] || (q > lim);
				if (over) begin
					fault_d = 1'b1;
					q       = lim;
				end
				res_d[l] = neg ? (~q[FX_W-1:0] + 1'b1) : q[FX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= QBITS; k++)
				vld_sn[k] <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			vld_sn[0]   <= v_s1;
			for (int k = 1; k <= QBITS; k++)
				vld_sn[k] <= vld_sn[k-1];
			out_valid_q <= vld_sn[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1         <= ctx1_d;
			ctx_sn[0]      <= ctx0_d;
			for (int l = 0; l < LANES; l++) begin
				rem_sn[0][l] <= rem0_d[l];
				quo_sn[0][l] <= '0;
			end
			for (int k = 1; k <= QBITS; k++) begin
				ctx_sn[k] <= ctx_sn[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_sn[k][l] <= rem_d[k][l];
					quo_sn[k][l] <= quo_d[k][l];
				end
			end
			for (int l = 0; l < LANES; l++)
				res_q[l] <= res_d[l];
			fault_q <= fault_d;
		end
	end

endmodule

[src/homogeneous_point_transform.sv]
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 column-major point transform with perspective divide, signed fixed point
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// in       | in_valid / in_ready   | in_x, in_y, in_z
// out      | out_valid / out_ready | out_x, out_y, out_z, divide_fault
// cfg      | cfg_write             | cfg_index, cfg_data
//
// one point per cycle unless the output stalls; a point passes the front stages,
// queue, divide pipeline (one quotient bit per stage) and the output register
// reset loads the identity matrix and empties the pipeline
// a stalled output freezes the divide pipeline; the front keeps going until
// the two-entry queue fills
// ----------------------------------------------------------------------------
module homogeneous_point_transform import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [FX_W-1:0] in_x,
	input  logic signed [FX_W-1:0] in_y,
	input  logic signed [FX_W-1:0] in_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [FX_W-1:0] out_x,
	output logic signed [FX_W-1:0] out_y,
	output logic signed [FX_W-1:0] out_z,
	output logic                   divide_fault
);

	localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + FX_W);

	logic [CFG_W-1:0] regs_q [NUM_REGS];
	hpt_mat_t         mat;
	hpt_q_stat_t      q_stat;
	hpt_sum_t         push_data, pop_data;
	logic             push, pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (i == 0 || i == 5)
					regs_q[i] <= ONE_LO;
				else if (i == 2 || i == 7)
					regs_q[i] <= ONE_HI;
				else
					regs_q[i] <= '0;
			end
		end else if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			regs_q[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				mat[c][r] = regs_q[c*2 + r/2][(r%2)*FX_W +: FX_W];
	end

	hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .mat(mat),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.q_stat(q_stat), .push(push), .push_data(push_data)
	);

	hpt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data), .q_stat(q_stat), .count(q_count)
	);

	hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_stat(q_stat), .pop_data(pop_data),
		.pop(pop), .out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.divide_fault(divide_fault)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_count == $past(q_count) + 1'b1)
		else $error("queue count lost a push");

endmodule

[tb/homogeneous_point_transform_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_tb
// drives points through the transform under several matrices and compares
// every result against a bit-exact fixed-point predictor held in a scoreboard
// ----------------------------------------------------------------------------
module homogeneous_point_transform_tb import hpt_pkg::*;;

	localparam int FB        = FRAC_BITS_DEF;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 60;

	typedef struct {
		logic [FX_W-1:0] x;
		logic [FX_W-1:0] y;
		logic [FX_W-1:0] z;
		logic            fault;
	} point_res_t;

	class transform_scoreboard;
		logic [CFG_W-1:0] regs [NUM_REGS];
		point_res_t       pending[$];
		int               errors;

		function new();
			errors = 0;
			regs[0] = 64'd1 << FB;
			regs[1] = 0;
			regs[2] = (64'd1 << FB) << 32;
			regs[3] = 0;
			regs[4] = 0;
			regs[5] = 64'd1 << FB;
			regs[6] = 0;
			regs[7] = (64'd1 << FB) << 32;
		endfunction

		function void write_reg(int idx, logic [CFG_W-1:0] val);
			if (idx < NUM_REGS)
				regs[idx] = val;
		endfunction

		function logic signed [FX_W-1:0] entry(int col, int row);
			logic [CFG_W-1:0] r;
			r = regs[col * 2 + row / 2];
			return (row % 2) ? r[63:32] : r[31:0];
		endfunction

		function logic signed [SUM_W-1:0] row_sum(logic signed [FX_W-1:0] p [3], int row);
			logic signed [SUM_W-1:0] acc;
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += SUM_W'(p[c]) * SUM_W'(entry(c, row));
			acc += SUM_W'(entry(3, row)) <<< FB;
			return acc;
		endfunction

		function logic [FX_W-1:0] quotient(logic signed [SUM_W-1:0] num,
				logic signed [SUM_W-1:0] den, ref logic fault);
			logic [SUM_W+FB-1:0] n;
			logic [SUM_W+FB-1:0] d;
			logic [SUM_W+FB-1:0] q;
			logic                neg;
			logic [SUM_W+FB-1:0] lim;
			if (den == 0) begin
				fault = 1;
				if (num == 0)
					return 0;
				return num < 0 ? FX_MIN : FX_MAX;
			end
			neg = (num < 0) != (den < 0);
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			q = (n << FB) / d;
			lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
			if (q > lim) begin
				fault = 1;
				q = lim;
			end
			return neg ? FX_W'(-q) : FX_W'(q);
		endfunction

		function void note_point(logic [FX_W-1:0] x, logic [FX_W-1:0] y, logic [FX_W-1:0] z);
			logic signed [FX_W-1:0]  p [3];
			logic signed [SUM_W-1:0] w;
			logic                    f;
			point_res_t              r;
			p[0] = x;
			p[1] = y;
			p[2] = z;
			f = 0;
			w = row_sum(p, 3);
			r.x = quotient(row_sum(p, 0), w, f);
			r.y = quotient(row_sum(p, 1), w, f);
			r.z = quotient(row_sum(p, 2), w, f);
			r.fault = f;
			pending.push_back(r);
		endfunction

		function void check_result(logic [FX_W-1:0] x, logic [FX_W-1:0] y,
				logic [FX_W-1:0] z, logic f);
			point_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$error("out_x expected %h actual %h", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("out_y expected %h actual %h", e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$error("out_z expected %h actual %h", e.z, z);
				errors++;
			end
			if (f !== e.fault) begin
				$error("divide_fault expected %b actual %b", e.fault, f);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [FX_W-1:0] in_x;
	logic signed [FX_W-1:0] in_y;
	logic signed [FX_W-1:0] in_z;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [FX_W-1:0] out_x;
	logic signed [FX_W-1:0] out_y;
	logic signed [FX_W-1:0] out_z;
	logic                   divide_fault;

	transform_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int wdog;

	homogeneous_point_transform u_top (.*);

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		in_x = 0;
		in_y = 0;
		in_z = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sb = new();
	end

	// receiver side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_x, out_y, out_z, divide_fault);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// valid stays high after the transaction until the next idle or drain
	task automatic send_point(logic [FX_W-1:0] x, logic [FX_W-1:0] y, logic [FX_W-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_point(x, y, z);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_cfg(int idx, logic [CFG_W-1:0] val);
		cfg_write <= 1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_write <= 0;
		@(posedge clk);
	endtask

	function automatic logic [FX_W-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return FX_W'($signed($urandom_range(16'hffff, 0)) - 32768) <<< 4;
			2: return $urandom_range(1) ? FX_MAX : FX_MIN;
			default: return FX_W'($signed($urandom_range(2000)) - 1000);
		endcase
	endfunction

	function automatic logic [FX_W-1:0] rand_entry(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(1) ? FX_MAX : FX_MIN;
			2: return 0;
			default: return FX_W'($signed($urandom_range(2 << FB)) - (1 << FB));
		endcase
	endfunction

	task automatic random_matrix(int mode);
		for (int i = 0; i < NUM_REGS; i++)
			write_cfg(i, {rand_entry(mode == 0 ? $urandom_range(3) : mode),
				rand_entry(mode == 0 ? $urandom_range(3) : mode)});
	endtask

	task automatic random_points(int n);
		for (int i = 0; i < n; i++)
			send_point(rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
				rand_coord($urandom_range(3)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset identity matrix, field extremes
		send_point(0, 0, 0);
		send_point(FX_MAX, FX_MIN, FX_MAX);
		send_point(FX_MIN, FX_MAX, 32'd1 << FB);
		send_point(32'hffff_ffff, 32'd1, 32'h0001_8000);
		drain();

		// w row zero: saturation by sign, zero numerator
		write_cfg(7, 0);
		write_cfg(15, 64'hffff_ffff_ffff_ffff);
		send_point(32'd1 << FB, 32'hffff_0000, 0);
		send_point(0, 0, 0);
		send_point(FX_MIN, FX_MAX, 5);
		drain();

		// tiny w: quotient overflow; negative w: truncation toward zero
		write_cfg(7, {32'd1, 32'd0});
		send_point(32'd100 << FB, 32'hff9c_0000, 1);
		drain();
		write_cfg(7, {32'hfffd_0000, 32'd0});
		send_point(32'd1 << FB, 32'h0002_0000, 32'hfffe_0000);
		send_point(7, 32'hffff_fff9, 3);
		drain();

		// extreme matrices
		random_matrix(1);
		send_point(FX_MAX, FX_MAX, FX_MAX);
		send_point(FX_MIN, FX_MIN, FX_MIN);
		send_point(FX_MIN, FX_MAX, 0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 32 : 0;
			for (int m = 0; m < 5; m++) begin
				random_matrix(m == 4 ? 0 : 3 - (m % 2) * 3);
				random_points(70);
				drain();
			end
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
